### hdl/swa_pkg.sv
// shared types and constants for the stereo widen / auto-pan block
`timescale 1ns / 1ps
package swa_pkg;

  // bits of the multiplier operand consumed per cycle
  localparam int DIGIT = 4;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_WIDEN_EN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AUTOPAN_EN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_PAN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_PAN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PAN_FRAC    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LEN   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_RECIP = 3'd7;

  localparam logic [15:0] RST_PAN_GAIN  = 16'd23170;
  localparam logic [15:0] RST_PAN_FRAC  = 16'd16512;
  localparam logic [12:0] RST_BLOCK_LEN = 13'd128;
  localparam logic [16:0] RST_RECIP     = 17'd512;
  localparam logic [15:0] FRAC_ONE      = 16'd32768;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_W1,
    ST_W2,
    ST_P1,
    ST_P2,
    ST_P3,
    ST_P4,
    ST_P5,
    ST_FIN
  } swa_state_t;

endpackage

### hdl/swa_mul.sv
// digit-serial signed by unsigned shift-add multiplier
`timescale 1ns / 1ps
module swa_mul #(
  parameter int AW = 30,
  parameter int BW = 17
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [AW-1:0]     a,
  input  logic        [BW-1:0]     b,
  output logic                     done,
  output logic signed [AW+BW-1:0]  p
);

  localparam int PW = AW + BW;
  localparam int DIG = swa_pkg::DIGIT;
  localparam int STEPS = (BW + DIG - 1) / DIG;
  localparam int BRW = STEPS * DIG;
  localparam int CNW = $clog2(STEPS + 1);

  logic signed [PW-1:0]  a_r, a_nxt;
  logic        [BRW-1:0] b_r, b_nxt;
  logic signed [PW-1:0]  acc_r, acc_nxt;
  logic        [CNW-1:0] cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic signed [PW+DIG:0] part;

  assign part = a_r * $signed({1'b0, b_r[DIG-1:0]});

  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt = PW'(a);
      b_nxt = BRW'(b);
      acc_nxt = '0;
      cnt_nxt = CNW'(STEPS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = acc_r + part[PW-1:0];
      a_nxt = a_r <<< DIG;
      b_nxt = b_r >> DIG;
      cnt_nxt = cnt_r - CNW'(1);
      if (cnt_r == CNW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    acc_r <= acc_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign p = acc_r;

endmodule

### hdl/stereo_widen_autopan_core.sv
// top level: config registers, sequencer and datapath around the serial multiplier
//
//   channel | direction | ports                                  | handshake
//   in      | input     | in_left/right_sample, in_lfo_*_value   | in_valid / in_ready
//   out     | output    | out_left_out, out_right_out, out_clipped | out_valid / out_ready
//   cfg     | input     | cfg_index, cfg_wdata                   | cfg_we, no wait
//
// each product runs on one multiplier, DIGIT bits per cycle: a start, 17 / 4 rounded up
// digit steps and a done. widening takes 4 products, auto-pan 10, plus an accept and an
// output load. reset is synchronous; no clearing pass.
// a stalled output holds in its register while the next item is computed; that item then
// waits in FIN until the output is taken, and the input stays blocked meanwhile.
`timescale 1ns / 1ps
module stereo_widen_autopan_core #(
  parameter int MAX_BLOCK = 4096,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [SAMPLE_BITS-1:0]     in_left_sample,
  input  logic signed [SAMPLE_BITS-1:0]     in_right_sample,
  input  logic        [15:0]                in_lfo_left_value,
  input  logic        [15:0]                in_lfo_right_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [SAMPLE_BITS-1:0]     out_left_out,
  output logic signed [SAMPLE_BITS-1:0]     out_right_out,
  output logic                              out_clipped,
  input  logic                              cfg_we,
  input  logic [swa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [swa_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int SB = SAMPLE_BITS;
  localparam int NW = $clog2(MAX_BLOCK + 1);
  localparam int PSW = $clog2(MAX_BLOCK);
  localparam int CW = (NW > 13) ? NW : 13;
  localparam int ACW = 16 + NW;
  localparam int AW = (SB + 1 > ACW + 1) ? SB + 1 : ACW + 1;
  localparam int BW = (NW > 17) ? NW : 17;
  localparam int PW = AW + BW;

  localparam logic signed [PW-1:0] SAT_HI = (PW'(1) <<< (SB - 1)) - PW'(1);
  localparam logic signed [PW-1:0] SAT_LO = -SAT_HI - PW'(1);
  localparam logic signed [PW-1:0] PP_MAX = PW'(65535);

  // config registers
  logic        widen_en_r, autopan_en_r;
  logic [15:0] width_gain_r, left_pan_r, right_pan_r, pan_frac_r;
  logic [12:0] block_len_r;
  logic [16:0] recip_r;

  // state
  swa_pkg::swa_state_t state_r, state_nxt;
  logic                go_r, go_nxt;
  logic                ch_r, ch_nxt;
  logic [PSW-1:0]      pos_r, pos_nxt;
  logic [NW-1:0]       n_r, n_nxt, i_r, i_nxt;
  logic [15:0]         lls_r, lls_nxt, lrs_r, lrs_nxt, lle_r, lle_nxt, lre_r, lre_nxt;
  logic signed [SB-1:0] xl_r, xl_nxt, xr_r, xr_nxt, yl_r, yl_nxt, w_r, w_nxt;
  logic [ACW-1:0]      acc_r, acc_nxt;
  logic [15:0]         pp_r, pp_nxt;
  logic [16:0]         g_r, g_nxt;
  logic                clip_r, clip_nxt;
  logic                ov_r, ov_nxt;
  logic signed [SB-1:0] ol_r, ol_nxt, or_r, or_nxt;
  logic                oc_r, oc_nxt;

  // multiplier hookup
  logic                 m_start, m_done;
  logic signed [AW-1:0] m_a;
  logic        [BW-1:0] m_b;
  logic signed [PW-1:0] m_p;

  swa_mul #(.AW(AW), .BW(BW)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(m_start), .a(m_a), .b(m_b), .done(m_done), .p(m_p)
  );

  // block length and position for the item at the input
  logic [CW-1:0]  bl_ext, n_c;
  logic [NW-1:0]  n_in, i_in, i_inc;

  always_comb begin
    bl_ext = CW'(block_len_r);
    if (bl_ext == '0) n_c = CW'(1);
    else if (bl_ext > CW'(MAX_BLOCK)) n_c = CW'(MAX_BLOCK);
    else n_c = bl_ext;
    n_in = NW'(n_c);
    i_in = (NW'(pos_r) >= n_in) ? '0 : NW'(pos_r);
    i_inc = i_in + NW'(1);
  end

  // datapath terms
  logic signed [PW-1:0] wa_e, wb_e, diff_e, t_e, w_raw, r15, r16;
  logic signed [SB-1:0] x_cur;
  logic [15:0]          frac_cur, comp;
  logic                 sat_clip;
  logic signed [SB-1:0] sat_val;
  logic signed [PW-1:0] sat_in;

  assign comp = (pan_frac_r < swa_pkg::FRAC_ONE) ? swa_pkg::FRAC_ONE - pan_frac_r : '0;
  assign frac_cur = ch_r ? comp : pan_frac_r;
  assign x_cur = ch_r ? xr_r : xl_r;
  assign wa_e = PW'(ch_r ? xr_r : xl_r);
  assign wb_e = PW'(ch_r ? xl_r : xr_r);
  assign diff_e = wa_e - wb_e;
  assign t_e = ((wa_e + wb_e) <<< 13) + m_p;
  assign w_raw = (t_e + (PW'(1) <<< 13)) >>> 14;
  assign r15 = (m_p + (PW'(1) <<< 14)) >>> 15;
  assign r16 = (m_p + (PW'(1) <<< 15)) >>> 16;
  assign sat_in = (state_r == swa_pkg::ST_W1) ? w_raw : r15;

  always_comb begin
    sat_clip = 1'b0;
    sat_val = sat_in[SB-1:0];
    if (sat_in > SAT_HI) begin
      sat_clip = 1'b1;
      sat_val = SAT_HI[SB-1:0];
    end else if (sat_in < SAT_LO) begin
      sat_clip = 1'b1;
      sat_val = SAT_LO[SB-1:0];
    end
  end

  // operand select
  always_comb begin
    m_a = '0;
    m_b = '0;
    case (state_r)
      swa_pkg::ST_W1: begin
        m_a = diff_e[AW-1:0];
        m_b = BW'(width_gain_r);
      end
      swa_pkg::ST_W2: begin
        m_a = AW'(w_r);
        m_b = BW'(ch_r ? right_pan_r : left_pan_r);
      end
      swa_pkg::ST_P1: begin
        m_a = AW'(ch_r ? lrs_r : lls_r);
        m_b = BW'(n_r - i_r);
      end
      swa_pkg::ST_P2: begin
        m_a = AW'(ch_r ? lre_r : lle_r);
        m_b = BW'(i_r);
      end
      swa_pkg::ST_P3: begin
        m_a = AW'(acc_r);
        m_b = BW'(recip_r);
      end
      swa_pkg::ST_P4: begin
        m_a = AW'(pp_r);
        m_b = BW'(frac_cur);
      end
      swa_pkg::ST_P5: begin
        m_a = AW'(x_cur);
        m_b = BW'(g_r);
      end
      default: begin
        m_a = '0;
        m_b = '0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    go_nxt = go_r;
    ch_nxt = ch_r;
    pos_nxt = pos_r;
    n_nxt = n_r;
    i_nxt = i_r;
    lls_nxt = lls_r;
    lrs_nxt = lrs_r;
    lle_nxt = lle_r;
    lre_nxt = lre_r;
    xl_nxt = xl_r;
    xr_nxt = xr_r;
    yl_nxt = yl_r;
    w_nxt = w_r;
    acc_nxt = acc_r;
    pp_nxt = pp_r;
    g_nxt = g_r;
    clip_nxt = clip_r;
    ov_nxt = ov_r & ~out_ready;
    ol_nxt = ol_r;
    or_nxt = or_r;
    oc_nxt = oc_r;
    m_start = 1'b0;
    in_ready = 1'b0;

    case (state_r)
      swa_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          xl_nxt = in_left_sample;
          xr_nxt = in_right_sample;
          n_nxt = n_in;
          i_nxt = i_in;
          pos_nxt = (i_inc >= n_in) ? '0 : PSW'(i_inc);
          clip_nxt = 1'b0;
          ch_nxt = 1'b0;
          go_nxt = 1'b0;
          if (autopan_en_r && i_in == '0) begin
            lls_nxt = lle_r;
            lrs_nxt = lre_r;
            lle_nxt = in_lfo_left_value;
            lre_nxt = in_lfo_right_value;
          end
          if (widen_en_r) state_nxt = swa_pkg::ST_W1;
          else if (autopan_en_r) state_nxt = swa_pkg::ST_P1;
          else state_nxt = swa_pkg::ST_FIN;
        end
      end
      swa_pkg::ST_FIN: begin
        if (!ov_r || out_ready) begin
          ov_nxt = 1'b1;
          ol_nxt = xl_r;
          or_nxt = xr_r;
          oc_nxt = clip_r;
          state_nxt = swa_pkg::ST_IDLE;
        end
      end
      default: begin
        if (!go_r) begin
          m_start = 1'b1;
          go_nxt = 1'b1;
        end else if (m_done) begin
          go_nxt = 1'b0;
          case (state_r)
            swa_pkg::ST_W1: begin
              w_nxt = sat_val;
              clip_nxt = clip_r | sat_clip;
              state_nxt = swa_pkg::ST_W2;
            end
            swa_pkg::ST_W2: begin
              clip_nxt = clip_r | sat_clip;
              if (!ch_r) begin
                yl_nxt = sat_val;
                ch_nxt = 1'b1;
                state_nxt = swa_pkg::ST_W1;
              end else begin
                xl_nxt = yl_r;
                xr_nxt = sat_val;
                ch_nxt = 1'b0;
                state_nxt = autopan_en_r ? swa_pkg::ST_P1 : swa_pkg::ST_FIN;
              end
            end
            swa_pkg::ST_P1: begin
              acc_nxt = m_p[ACW-1:0];
              state_nxt = swa_pkg::ST_P2;
            end
            swa_pkg::ST_P2: begin
              acc_nxt = acc_r + m_p[ACW-1:0];
              state_nxt = swa_pkg::ST_P3;
            end
            swa_pkg::ST_P3: begin
              // interpolated lfo gain, held to 16 bits
              pp_nxt = (r16 > PP_MAX) ? 16'hFFFF : r16[15:0];
              state_nxt = swa_pkg::ST_P4;
            end
            swa_pkg::ST_P4: begin
              g_nxt = r15[16:0];
              state_nxt = swa_pkg::ST_P5;
            end
            swa_pkg::ST_P5: begin
              clip_nxt = clip_r | sat_clip;
              if (!ch_r) begin
                xl_nxt = sat_val;
                ch_nxt = 1'b1;
                state_nxt = swa_pkg::ST_P1;
              end else begin
                xr_nxt = sat_val;
                state_nxt = swa_pkg::ST_FIN;
              end
            end
            default: state_nxt = swa_pkg::ST_IDLE;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    n_r <= n_nxt;
    i_r <= i_nxt;
    xl_r <= xl_nxt;
    xr_r <= xr_nxt;
    yl_r <= yl_nxt;
    w_r <= w_nxt;
    acc_r <= acc_nxt;
    pp_r <= pp_nxt;
    g_r <= g_nxt;
    ol_r <= ol_nxt;
    or_r <= or_nxt;
    oc_r <= oc_nxt;
    if (!rst_n) begin
      state_r <= swa_pkg::ST_IDLE;
      go_r <= 1'b0;
      ch_r <= 1'b0;
      pos_r <= '0;
      lls_r <= '0;
      lrs_r <= '0;
      lle_r <= '0;
      lre_r <= '0;
      clip_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      go_r <= go_nxt;
      ch_r <= ch_nxt;
      pos_r <= pos_nxt;
      lls_r <= lls_nxt;
      lrs_r <= lrs_nxt;
      lle_r <= lle_nxt;
      lre_r <= lre_nxt;
      clip_r <= clip_nxt;
      ov_r <= ov_nxt;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      widen_en_r <= 1'b0;
      autopan_en_r <= 1'b0;
      width_gain_r <= '0;
      left_pan_r <= swa_pkg::RST_PAN_GAIN;
      right_pan_r <= swa_pkg::RST_PAN_GAIN;
      pan_frac_r <= swa_pkg::RST_PAN_FRAC;
      block_len_r <= swa_pkg::RST_BLOCK_LEN;
      recip_r <= swa_pkg::RST_RECIP;
    end else if (cfg_we) begin
      case (cfg_index)
        swa_pkg::REG_WIDEN_EN:    widen_en_r <= cfg_wdata[0];
        swa_pkg::REG_AUTOPAN_EN:  autopan_en_r <= cfg_wdata[0];
        swa_pkg::REG_WIDTH_GAIN:  width_gain_r <= cfg_wdata[15:0];
        swa_pkg::REG_LEFT_PAN:    left_pan_r <= cfg_wdata[15:0];
        swa_pkg::REG_RIGHT_PAN:   right_pan_r <= cfg_wdata[15:0];
        swa_pkg::REG_PAN_FRAC:    pan_frac_r <= cfg_wdata[15:0];
        swa_pkg::REG_BLOCK_LEN:   block_len_r <= cfg_wdata[12:0];
        swa_pkg::REG_BLOCK_RECIP: recip_r <= cfg_wdata[16:0];
        default: ;
      endcase
    end
  end

  assign out_valid = ov_r;
  assign out_left_out = ol_r;
  assign out_right_out = or_r;
  assign out_clipped = oc_r;

endmodule

### verif/tb_stereo_widen_autopan_core.sv
// testbench for the stereo widen / auto-pan core: directed and random items checked against a local predictor
`timescale 1ns / 1ps
module tb_stereo_widen_autopan_core;

  localparam int SB = 24;
  localparam int MAXB = 4096;
  localparam longint CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [SB-1:0] in_left_sample = '0;
  logic signed [SB-1:0] in_right_sample = '0;
  logic [15:0] in_lfo_left_value = '0;
  logic [15:0] in_lfo_right_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SB-1:0] out_left_out;
  logic signed [SB-1:0] out_right_out;
  logic out_clipped;
  logic cfg_we = 1'b0;
  logic [swa_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [swa_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  typedef struct packed {
    logic signed [SB-1:0] left;
    logic signed [SB-1:0] right;
    logic clip;
  } pair_t;

  pair_t expected_pairs[$];

  // predictor copy of registers and state
  logic m_widen, m_autopan;
  logic [15:0] m_width, m_lpan, m_rpan, m_frac;
  logic [12:0] m_blen;
  logic [16:0] m_recip;
  logic [11:0] m_pos;
  logic [15:0] m_lstart, m_rstart, m_lend, m_rend;
  logic m_clip;

  int errors = 0;
  int mismatches = 0;
  int items_sent = 0;
  int results_seen = 0;
  int clip_count = 0;
  longint cycles = 0;
  logic long_hold = 1'b0;
  int sink_long_gaps = 1;
  int sink_hold = 0;

  stereo_widen_autopan_core i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  function automatic longint sat_sample(longint v);
    longint hi, lo;
    hi = (64'sd1 <<< (SB - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      m_clip = 1'b1;
      return hi;
    end
    if (v < lo) begin
      m_clip = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // arithmetic shift floors, which with the added half gives round half up
  function automatic longint rnd_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint widen_chan(longint a, longint b, logic [15:0] pan);
    longint t, w;
    t = (a + b) * 8192 + (a - b) * longint'(m_width);
    w = sat_sample(rnd_shift(t, 14));
    return sat_sample(rnd_shift(w * longint'(pan), 15));
  endfunction

  function automatic longint pan_chan(longint x, logic [15:0] st, logic [15:0] en,
                                      longint n, longint i, longint frac);
    longint acc, pp, g;
    acc = longint'(st) * (n - i) + longint'(en) * i;
    pp = (acc * longint'(m_recip) + 32768) >>> 16;
    if (pp > 65535) pp = 65535;
    g = (pp * frac + 16384) >>> 15;
    return sat_sample(rnd_shift(x * g, 15));
  endfunction

  function automatic pair_t predict_pair(logic signed [SB-1:0] ls, logic signed [SB-1:0] rs,
                                         logic [15:0] lv, logic [15:0] rv);
    longint l, r, nl, nr, n, i, comp;
    pair_t p;
    l = ls;
    r = rs;
    n = m_blen;
    i = m_pos;
    if (n == 0) n = 1;
    if (n > MAXB) n = MAXB;
    if (i >= n) i = 0;
    m_clip = 1'b0;
    if (m_widen) begin
      nl = widen_chan(l, r, m_lpan);
      nr = widen_chan(r, l, m_rpan);
      l = nl;
      r = nr;
    end
    if (m_autopan) begin
      comp = (m_frac < 32768) ? 32768 - longint'(m_frac) : 0;
      if (i == 0) begin
        m_lstart = m_lend;
        m_rstart = m_rend;
        m_lend = lv;
        m_rend = rv;
      end
      l = pan_chan(l, m_lstart, m_lend, n, i, longint'(m_frac));
      r = pan_chan(r, m_rstart, m_rend, n, i, comp);
    end
    i++;
    m_pos = (i >= n) ? 12'd0 : i[11:0];
    p.left = l[SB-1:0];
    p.right = r[SB-1:0];
    p.clip = m_clip;
    return p;
  endfunction

  task automatic reset_model();
    m_widen = 1'b0;
    m_autopan = 1'b0;
    m_width = '0;
    m_lpan = swa_pkg::RST_PAN_GAIN;
    m_rpan = swa_pkg::RST_PAN_GAIN;
    m_frac = swa_pkg::RST_PAN_FRAC;
    m_blen = swa_pkg::RST_BLOCK_LEN;
    m_recip = swa_pkg::RST_RECIP;
    m_pos = '0;
    m_lstart = '0;
    m_rstart = '0;
    m_lend = '0;
    m_rend = '0;
  endtask

  task automatic write_reg(logic [swa_pkg::CFG_IDX_W-1:0] idx, int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[swa_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      swa_pkg::REG_WIDEN_EN:    m_widen = val[0];
      swa_pkg::REG_AUTOPAN_EN:  m_autopan = val[0];
      swa_pkg::REG_WIDTH_GAIN:  m_width = val[15:0];
      swa_pkg::REG_LEFT_PAN:    m_lpan = val[15:0];
      swa_pkg::REG_RIGHT_PAN:   m_rpan = val[15:0];
      swa_pkg::REG_PAN_FRAC:    m_frac = val[15:0];
      swa_pkg::REG_BLOCK_LEN:   m_blen = val[12:0];
      swa_pkg::REG_BLOCK_RECIP: m_recip = val[16:0];
      default: ;
    endcase
  endtask

  // block length with the matching Q1.16 reciprocal
  task automatic set_block(int n);
    write_reg(swa_pkg::REG_BLOCK_LEN, n);
    write_reg(swa_pkg::REG_BLOCK_RECIP, (n == 0) ? 65536 : 65536 / n);
  endtask

  task automatic wait_drained();
    while (expected_pairs.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic send_pair(logic signed [SB-1:0] ls, logic signed [SB-1:0] rs,
                           logic [15:0] lv, logic [15:0] rv, bit gaps = 1);
    int gap;
    gap = 1;
    if (gaps) begin
      gap = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 90) : $urandom_range(1, 3);
    end
    repeat (gap) @(posedge clk);
    in_valid <= 1'b1;
    in_left_sample <= ls;
    in_right_sample <= rs;
    in_lfo_left_value <= lv;
    in_lfo_right_value <= rv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_pairs.push_back(predict_pair(ls, rs, lv, rv));
    items_sent++;
    in_valid <= 1'b0;
  endtask

  function automatic logic signed [SB-1:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return {1'b0, {(SB-1){1'b1}}};
      1: return {1'b1, {(SB-1){1'b0}}};
      2: return SB'(int'($urandom_range(0, 255)) - 128);
      default: return SB'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_gain();
    case ($urandom_range(0, 4))
      0: return 16'd0;
      1: return swa_pkg::FRAC_ONE;
      2: return 16'hFFFF;
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  task automatic send_random(int count);
    repeat (count) send_pair(rand_sample(), rand_sample(), rand_gain(), rand_gain());
  endtask

  // receiver: random stalls, occasional long ones, and one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      sink_hold <= 0;
    end else if (long_hold) begin
      out_ready <= 1'b0;
    end else if (sink_hold != 0) begin
      out_ready <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else if ($urandom_range(0, 59) == 0 && sink_long_gaps != 0) begin
      out_ready <= 1'b0;
      sink_hold <= $urandom_range(20, 80);
    end else begin
      out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    pair_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (out_clipped) clip_count++;
      if (expected_pairs.size() == 0) begin
        errors++;
        if (mismatches < 10) $display("unexpected result item at cycle %0d", cycles);
        mismatches++;
      end else begin
        want = expected_pairs.pop_front();
        if (want.left !== out_left_out || want.right !== out_right_out ||
            want.clip !== out_clipped) begin
          errors++;
          if (mismatches < 10)
            $display("mismatch item %0d: exp L=%0d R=%0d clip=%0b got L=%0d R=%0d clip=%0b",
                     results_seen, want.left, want.right, want.clip,
                     out_left_out, out_right_out, out_clipped);
          mismatches++;
        end
      end
    end
  end

  task automatic test_bypass();
    send_pair({1'b0, {(SB-1){1'b1}}}, {1'b1, {(SB-1){1'b0}}}, 16'd0, 16'hFFFF);
    send_pair('0, -24'sd1, 16'hFFFF, 16'd0);
    send_random(4);
    wait_drained();
  endtask

  task automatic test_widen_extremes();
    write_reg(swa_pkg::REG_WIDEN_EN, 1);
    write_reg(swa_pkg::REG_WIDTH_GAIN, 16'hFFFF);
    write_reg(swa_pkg::REG_LEFT_PAN, 16'hFFFF);
    write_reg(swa_pkg::REG_RIGHT_PAN, swa_pkg::FRAC_ONE);
    send_pair({1'b0, {(SB-1){1'b1}}}, {1'b1, {(SB-1){1'b0}}}, 16'd0, 16'd0);
    send_pair({1'b1, {(SB-1){1'b0}}}, {1'b0, {(SB-1){1'b1}}}, 16'd0, 16'd0);
    wait_drained();
    write_reg(swa_pkg::REG_WIDTH_GAIN, 0);
    write_reg(swa_pkg::REG_LEFT_PAN, 0);
    send_pair(24'sd1000, -24'sd3, 16'd0, 16'd0);
    wait_drained();
    write_reg(swa_pkg::REG_WIDTH_GAIN, 32768);
    write_reg(swa_pkg::REG_LEFT_PAN, 23170);
    send_random(4);
    wait_drained();
  endtask

  task automatic test_autopan_blocks();
    write_reg(swa_pkg::REG_WIDEN_EN, 0);
    write_reg(swa_pkg::REG_AUTOPAN_EN, 1);
    write_reg(swa_pkg::REG_PAN_FRAC, 16'hFFFF);
    set_block(3);
    send_pair(24'sd4000000, -24'sd4000000, 16'hFFFF, swa_pkg::FRAC_ONE);
    send_pair(24'sd4000000, -24'sd4000000, 16'd1, 16'd2);
    send_pair(24'sd4000000, -24'sd4000000, 16'd7, 16'd8);
    send_pair(24'sd100, 24'sd100, 16'd0, 16'd32768);
    // shrinking the block while mid-block restarts at position zero
    wait_drained();
    set_block(1);
    write_reg(swa_pkg::REG_PAN_FRAC, 0);
    send_pair(24'sd5, 24'sd5, 16'd9, 16'd9);
    wait_drained();
    // zero length behaves as one; oversize clamps to the maximum
    write_reg(swa_pkg::REG_BLOCK_LEN, 0);
    write_reg(swa_pkg::REG_BLOCK_RECIP, 17'h1FFFF);
    send_pair(-24'sd77, 24'sd77, 16'hFFFF, 16'hFFFF);
    wait_drained();
    set_block(8191);
    send_random(3);
    wait_drained();
  endtask

  task automatic test_both_stages();
    write_reg(swa_pkg::REG_WIDEN_EN, 1);
    write_reg(swa_pkg::REG_WIDTH_GAIN, 16384);
    write_reg(swa_pkg::REG_PAN_FRAC, 12000);
    set_block(4);
    send_random(5);
    wait_drained();
  endtask

  // receiver holds off while items keep coming, filling the output register and blocking the input
  task automatic test_backpressure();
    long_hold <= 1'b1;
    fork
      send_random(8);
      begin
        repeat (400) @(posedge clk);
        long_hold <= 1'b0;
      end
    join
    wait_drained();
  endtask

  task automatic test_random_phases();
    int k;
    for (k = 0; k < 12; k++) begin
      write_reg(swa_pkg::REG_WIDEN_EN, $urandom_range(0, 1));
      write_reg(swa_pkg::REG_AUTOPAN_EN, $urandom_range(0, 1));
      write_reg(swa_pkg::REG_WIDTH_GAIN, (k == 0) ? 16'hFFFF : rand_gain());
      write_reg(swa_pkg::REG_LEFT_PAN, rand_gain());
      write_reg(swa_pkg::REG_RIGHT_PAN, rand_gain());
      write_reg(swa_pkg::REG_PAN_FRAC, rand_gain());
      case (k % 4)
        0: set_block($urandom_range(1, 6));
        1: set_block($urandom_range(7, 40));
        2: begin
          write_reg(swa_pkg::REG_BLOCK_LEN, $urandom);
          write_reg(swa_pkg::REG_BLOCK_RECIP, $urandom);
        end
        default: set_block(k == 3 ? 4096 : $urandom_range(2, 12));
      endcase
      sink_long_gaps = (k % 3 != 0);
      send_random(76);
      wait_drained();
    end
    sink_long_gaps = 1;
  endtask

  initial begin
    reset_model();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_bypass();
    test_widen_extremes();
    test_autopan_blocks();
    test_both_stages();
    test_backpressure();
    test_random_phases();
    wait_drained();
    $display("sent %0d items, checked %0d results, %0d of them clipped",
             items_sent, results_seen, clip_count);
    $display("covered bypass, widening, auto-pan block ramps, odd block lengths, back-pressure");
    if (errors == 0 && expected_pairs.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d items missing", mismatches, expected_pairs.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule
